[hdl/tcw_pkg.sv]
// Shared constants, datapath operation codes and status type for the text console writer.
package tcw_pkg;

    localparam int ADDR_W = 13;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int DATA_W = 16;

    localparam logic [DATA_W-1:0] BLANK_WORD  = 16'h0700;
    localparam logic [DATA_W-1:0] SCROLL_WORD = 16'h0C00;

    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd10;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR,
        OP_LOAD,
        OP_RD_WRAP,
        OP_RD_TAKE,
        OP_PUT,
        OP_CR,
        OP_BS_STEP,
        OP_BLANK,
        OP_NL,
        OP_NEXT_ROW,
        OP_SCR_MOVE,
        OP_COPY_INIT,
        OP_COPY_RD,
        OP_COPY_WR,
        OP_FILL_INIT,
        OP_FILL,
        OP_FINISH
    } t_op;

    typedef struct packed {
        logic addr_hi;
        logic clr_last;
        logic col_zero;
        logic col_lt;
        logic put_wrap;
        logic last_row;
        logic fits;
        logic copy_last;
        logic fill_last;
    } t_dp_status;

endpackage

[hdl/tcw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/tcw_datapath.sv]
// Datapath: cursor, origin and address registers, video memory and result registers.
module tcw_datapath import tcw_pkg::*; #(
    parameter int MEMORY_WORDS   = 8192,
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_op               i_op,
    output t_dp_status        o_status,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [ADDR_W-1:0] i_read_address,
    input  logic              i_cfg_we,
    input  logic [ATTR_W-1:0] i_cfg_data,
    output logic [ADDR_W-1:0] o_cursor_address,
    output logic [ADDR_W-1:0] o_origin_address,
    output logic [DATA_W-1:0] o_read_data
);

    localparam int AW   = $clog2(MEMORY_WORDS);
    localparam int RW   = (AW > ADDR_W) ? AW : ADDR_W;
    localparam int SW0  = $clog2(MEMORY_WORDS + (SCREEN_ROWS + 1) * SCREEN_COLUMNS + 1);
    localparam int SW   = (SW0 > RW) ? SW0 : RW + 1;
    localparam int CW   = $clog2(SCREEN_COLUMNS + 2);
    localparam int RWD  = $clog2(SCREEN_ROWS);
    localparam int COPY_WORDS = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;
    localparam int NW   = $clog2(COPY_WORDS);

    localparam logic [SW-1:0] MW_S         = SW'(MEMORY_WORDS);
    localparam logic [SW-1:0] COLS_S       = SW'(SCREEN_COLUMNS);
    localparam logic [SW-1:0] LAST_ROW_OFS = SW'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);
    localparam logic [SW-1:0] FIT_OFS      = SW'((SCREEN_ROWS + 1) * SCREEN_COLUMNS);

    // One conditional subtract; inputs stay below twice the memory size.
    function automatic logic [AW-1:0] wrap1(input logic [SW-1:0] a);
        logic [AW-1:0] res;
        if (a >= MW_S) begin
            res = AW'(a - MW_S);
        end else begin
            res = AW'(a);
        end
        return res;
    endfunction

    logic [AW-1:0]     r_origin;
    logic [AW-1:0]     r_row_base;
    logic [RWD-1:0]    r_row;
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_addr;
    logic [AW-1:0]     r_src;
    logic [NW-1:0]     r_cnt;
    logic [ATTR_W-1:0] r_attr;
    logic [CHAR_W-1:0] r_char;
    logic [DATA_W-1:0] r_rdata;
    logic [ADDR_W-1:0] r_out_cursor;
    logic [ADDR_W-1:0] r_out_origin;
    logic [DATA_W-1:0] r_out_data;

    logic [AW-1:0]     cur_word;
    logic [CW-1:0]     col_inc;
    logic [AW-1:0]     fill_start;
    logic [AW-1:0]     origin_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    assign cur_word    = wrap1(SW'(r_row_base) + SW'(r_col));
    assign col_inc     = r_col + 1'b1;
    assign fill_start  = wrap1(SW'(r_origin) + LAST_ROW_OFS);
    assign origin_next = wrap1(SW'(r_origin) + COLS_S);

    assign o_status.addr_hi   = SW'(r_addr) >= MW_S;
    assign o_status.clr_last  = r_addr == RW'(MEMORY_WORDS - 1);
    assign o_status.col_zero  = r_col == '0;
    assign o_status.col_lt    = r_col < CW'(SCREEN_COLUMNS);
    assign o_status.put_wrap  = col_inc >= CW'(SCREEN_COLUMNS);
    assign o_status.last_row  = r_row == RWD'(SCREEN_ROWS - 1);
    assign o_status.fits      = (SW'(r_origin) + FIT_OFS) <= (MW_S - 1'b1);
    assign o_status.copy_last = r_cnt == NW'(COPY_WORDS - 1);
    assign o_status.fill_last = r_cnt == NW'(SCREEN_COLUMNS - 1);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cur_word;
        ram_wdata = BLANK_WORD;
        ram_re    = 1'b0;
        ram_raddr = r_addr[AW-1:0];
        case (i_op)
            OP_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr[AW-1:0];
            end
            OP_PUT: begin
                ram_we    = 1'b1;
                ram_wdata = {r_attr, r_char};
            end
            OP_NL, OP_BLANK: begin
                ram_we = 1'b1;
            end
            OP_COPY_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr[AW-1:0];
                ram_wdata = ram_rdata;
            end
            OP_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr[AW-1:0];
                ram_wdata = SCROLL_WORD;
            end
            OP_RD_WRAP: begin
                ram_re = !o_status.addr_hi;
            end
            OP_COPY_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_src;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin   <= '0;
            r_row_base <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_addr     <= '0;
            r_src      <= '0;
            r_cnt      <= '0;
            r_attr     <= ATTR_RESET;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
            case (i_op)
                OP_CLR: begin
                    r_addr <= r_addr + 1'b1;
                end
                OP_LOAD: begin
                    r_addr <= RW'(i_read_address);
                end
                OP_RD_WRAP: begin
                    if (o_status.addr_hi) begin
                        r_addr <= RW'(SW'(r_addr) - MW_S);
                    end
                end
                OP_PUT: begin
                    r_col <= o_status.put_wrap ? '0 : col_inc;
                end
                OP_CR: begin
                    r_col <= '0;
                end
                OP_BS_STEP: begin
                    r_col <= r_col - 1'b1;
                end
                OP_NL: begin
                    r_col <= col_inc;
                end
                OP_NEXT_ROW: begin
                    if (!o_status.last_row) begin
                        r_row      <= r_row + 1'b1;
                        r_row_base <= wrap1(SW'(r_row_base) + COLS_S);
                    end
                end
                OP_SCR_MOVE: begin
                    r_origin <= origin_next;
                end
                OP_COPY_INIT: begin
                    r_src  <= origin_next;
                    r_addr <= '0;
                    r_cnt  <= '0;
                end
                OP_COPY_WR: begin
                    r_addr <= r_addr + 1'b1;
                    r_src  <= wrap1(SW'(r_src) + SW'(1));
                    r_cnt  <= r_cnt + 1'b1;
                    if (o_status.copy_last) begin
                        r_origin <= '0;
                    end
                end
                OP_FILL_INIT: begin
                    r_addr     <= RW'(fill_start);
                    r_row_base <= fill_start;
                    r_cnt      <= '0;
                end
                OP_FILL: begin
                    r_addr <= RW'(wrap1(SW'(r_addr) + SW'(1)));
                    r_cnt  <= r_cnt + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_char  <= i_char_code;
                r_rdata <= '0;
            end
            OP_RD_TAKE: begin
                r_rdata <= ram_rdata;
            end
            OP_FINISH: begin
                r_out_cursor <= ADDR_W'(cur_word);
                r_out_origin <= ADDR_W'(r_origin);
                r_out_data   <= r_rdata;
            end
            default: begin
            end
        endcase
    end

    tcw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEMORY_WORDS)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_cursor_address = r_out_cursor;
    assign o_origin_address = r_out_origin;
    assign o_read_data      = r_out_data;

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= RWD'(SCREEN_ROWS - 1))
        else $error("cursor row past last screen row");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= CW'(SCREEN_COLUMNS))
        else $error("cursor column past row end");

    a_copy_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_COPY_WR && o_status.copy_last) |=> r_origin == '0)
        else $error("origin not reset after copy scroll");

endmodule

[hdl/tcw_ctrl.sv]
// Controller: sequences datapath operations for each beat and owns the handshakes.
module tcw_ctrl import tcw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_cmd,
    input  logic [CHAR_W-1:0] i_char_code,
    output logic              o_valid,
    input  logic              i_ready,
    input  t_dp_status        i_status,
    output t_op               o_op
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_WRAP,
        S_TAKE,
        S_CR,
        S_BS,
        S_BLANK,
        S_PUT,
        S_NL,
        S_NROW,
        S_SCROLL,
        S_COPY_RD,
        S_COPY_WR,
        S_FILL_INIT,
        S_FILL,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = r_state == S_IDLE;
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            S_CLEAR: begin
                o_op = OP_CLR;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_op = OP_LOAD;
                    if (i_cmd) begin
                        n_state = S_WRAP;
                    end else begin
                        case (i_char_code)
                            CODE_NEWLINE:   n_state = S_NL;
                            CODE_RETURN:    n_state = S_CR;
                            CODE_BACKSPACE: n_state = S_BS;
                            default:        n_state = S_PUT;
                        endcase
                    end
                end
            end
            S_WRAP: begin
                o_op = OP_RD_WRAP;
                if (!i_status.addr_hi) begin
                    n_state = S_TAKE;
                end
            end
            S_TAKE: begin
                o_op    = OP_RD_TAKE;
                n_state = S_FINISH;
            end
            S_CR: begin
                o_op    = OP_CR;
                n_state = S_FINISH;
            end
            S_BS: begin
                if (i_status.col_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_op    = OP_BS_STEP;
                    n_state = S_BLANK;
                end
            end
            S_BLANK: begin
                o_op    = OP_BLANK;
                n_state = S_FINISH;
            end
            S_PUT: begin
                o_op    = OP_PUT;
                n_state = i_status.put_wrap ? S_NROW : S_FINISH;
            end
            S_NL: begin
                if (i_status.col_lt) begin
                    o_op = OP_NL;
                end else begin
                    n_state = S_NROW;
                end
            end
            S_NROW: begin
                o_op    = OP_NEXT_ROW;
                n_state = i_status.last_row ? S_SCROLL : S_FINISH;
            end
            S_SCROLL: begin
                if (i_status.fits) begin
                    o_op    = OP_SCR_MOVE;
                    n_state = S_FILL_INIT;
                end else begin
                    o_op    = OP_COPY_INIT;
                    n_state = S_COPY_RD;
                end
            end
            S_COPY_RD: begin
                o_op    = OP_COPY_RD;
                n_state = S_COPY_WR;
            end
            S_COPY_WR: begin
                o_op    = OP_COPY_WR;
                n_state = i_status.copy_last ? S_FILL_INIT : S_COPY_RD;
            end
            S_FILL_INIT: begin
                o_op    = OP_FILL_INIT;
                n_state = S_FILL;
            end
            S_FILL: begin
                o_op = OP_FILL;
                if (i_status.fill_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    o_op    = OP_FINISH;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_op == OP_FINISH) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second beat taken while one is in work");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == OP_FINISH) |-> out_free)
        else $error("result register loaded while a result is pending");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid)) |-> $past(r_state == S_FINISH))
        else $error("result raised outside finish step");

endmodule

[hdl/text_console_writer.sv]
// Top level of the text console writer: controller plus datapath with video memory.
//
//  channel   | handshake           | payload
//  ----------+---------------------+----------------------------------------------
//  input     | i_valid / o_ready   | i_cmd, i_char_code, i_read_address
//  result    | o_valid / i_ready   | o_cursor_address, o_origin_address, o_read_data
//  config    | i_cfg_we            | i_cfg_data (text attribute)
//
//  Steps per beat: a character writes its cell and steps the cursor, with a row step on
//  row wrap; a read subtracts the memory size from the address until it is in range;
//  a newline blanks each cell to the row end. Scroll either moves the origin a row on or
//  copies the screen to memory start, then fills the last row.
//  Reset starts a clearing pass over all MEMORY_WORDS words writing 0x0700; o_ready low.
//  A stalled result holds the next beat in its finish step; o_ready stays low then.
module text_console_writer import tcw_pkg::*; #(
    parameter int MEMORY_WORDS   = 8192,
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_cmd,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [ADDR_W-1:0] i_read_address,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ADDR_W-1:0] o_cursor_address,
    output logic [ADDR_W-1:0] o_origin_address,
    output logic [DATA_W-1:0] o_read_data,
    input  logic              i_cfg_we,
    input  logic [ATTR_W-1:0] i_cfg_data
);

    t_op        op;
    t_dp_status status;

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_char_code (i_char_code),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .i_status    (status),
        .o_op        (op)
    );

    tcw_datapath #(
        .MEMORY_WORDS   (MEMORY_WORDS),
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .o_status         (status),
        .i_char_code      (i_char_code),
        .i_read_address   (i_read_address),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .o_cursor_address (o_cursor_address),
        .o_origin_address (o_origin_address),
        .o_read_data      (o_read_data)
    );

endmodule

[dv/tb.sv]
// Self-checking testbench for text_console_writer: queued stimulus, cycle driver, result checker.
`timescale 1ns / 1ps

module tb import tcw_pkg::*; ();

    localparam int MEM_WORDS = 8192;
    localparam int COLS      = 80;
    localparam int ROWS      = 25;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [CHAR_W-1:0] code;
        logic [ADDR_W-1:0] raddr;
    } t_con_item;

    typedef struct packed {
        logic [ADDR_W-1:0] cursor;
        logic [ADDR_W-1:0] origin;
        logic [DATA_W-1:0] data;
    } t_con_status;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_cmd = 1'b0;
    logic [CHAR_W-1:0] in_char = '0;
    logic [ADDR_W-1:0] in_raddr = '0;
    logic              res_ready = 1'b0;
    logic              cfg_we = 1'b0;
    logic [ATTR_W-1:0] cfg_data = '0;
    logic              o_ready;
    logic              o_valid;
    logic [ADDR_W-1:0] o_cursor_address;
    logic [ADDR_W-1:0] o_origin_address;
    logic [DATA_W-1:0] o_read_data;

    text_console_writer #(
        .MEMORY_WORDS  (MEM_WORDS),
        .SCREEN_COLUMNS(COLS),
        .SCREEN_ROWS   (ROWS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (in_valid),
        .o_ready         (o_ready),
        .i_cmd           (in_cmd),
        .i_char_code     (in_char),
        .i_read_address  (in_raddr),
        .o_valid         (o_valid),
        .i_ready         (res_ready),
        .o_cursor_address(o_cursor_address),
        .o_origin_address(o_origin_address),
        .o_read_data     (o_read_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // console shadow
    logic [DATA_W-1:0] vram [MEM_WORDS];
    int unsigned       scr_origin;
    int unsigned       crs_row;
    int unsigned       crs_col;
    int unsigned       crs_word;
    logic [ATTR_W-1:0] txt_attr;

    t_con_item   pend_q[$];
    t_con_status status_due_q[$];
    t_con_item   held_item;
    t_con_status got_status;
    t_con_status want_status;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          err_count = 0;

    function automatic int unsigned wrap_word(int unsigned a);
        return a % MEM_WORDS;
    endfunction

    function automatic int unsigned cell_word();
        return wrap_word(scr_origin + crs_row * COLS + crs_col);
    endfunction

    task automatic scroll_screen();
        int unsigned i;
        int unsigned base;
        if (scr_origin + (ROWS + 1) * COLS <= MEM_WORDS - 1) begin
            scr_origin = wrap_word(scr_origin + COLS);
        end else begin
            for (i = 0; i < (ROWS - 1) * COLS; i++)
                vram[wrap_word(i)] = vram[wrap_word(scr_origin + COLS + i)];
            scr_origin = 0;
        end
        base = scr_origin + (ROWS - 1) * COLS;
        for (i = 0; i < COLS; i++)
            vram[wrap_word(base + i)] = SCROLL_WORD;
    endtask

    task automatic advance_row();
        crs_row++;
        if (crs_row >= ROWS) begin
            crs_row = ROWS - 1;
            scroll_screen();
        end
    endtask

    task automatic put_code(logic [CHAR_W-1:0] c);
        if (c == CODE_NEWLINE) begin
            while (crs_col < COLS) begin
                vram[cell_word()] = BLANK_WORD;
                crs_col++;
            end
            advance_row();
            crs_word = cell_word();
        end else if (c == CODE_RETURN) begin
            crs_col  = 0;
            crs_word = cell_word();
        end else if (c == CODE_BACKSPACE) begin
            if (crs_col > 0) begin
                crs_col--;
                crs_word = cell_word();
                vram[crs_word] = BLANK_WORD;
            end
        end else begin
            vram[cell_word()] = {txt_attr, c};
            crs_col++;
            if (crs_col >= COLS) begin
                crs_col = 0;
                advance_row();
            end
            crs_word = cell_word();
        end
    endtask

    task automatic console_step(t_con_item it);
        t_con_status st;
        st.data = '0;
        if (it.cmd == CMD_PUT)
            put_code(it.code);
        else
            st.data = vram[wrap_word(it.raddr)];
        st.cursor = crs_word[ADDR_W-1:0];
        st.origin = scr_origin[ADDR_W-1:0];
        status_due_q.push_back(st);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_ready)
                console_step(held_item);
            if (!in_valid || o_ready) begin
                if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    held_item = pend_q.pop_front();
                    in_valid <= 1'b1;
                    in_cmd   <= held_item.cmd;
                    in_char  <= held_item.code;
                    in_raddr <= held_item.raddr;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (o_valid && res_ready) begin
                got_status = '{o_cursor_address, o_origin_address, o_read_data};
                if (status_due_q.size() == 0) begin
                    $error("unexpected result beat: cursor %0h origin %0h data %0h",
                           got_status.cursor, got_status.origin, got_status.data);
                    err_count++;
                end else begin
                    want_status = status_due_q.pop_front();
                    if (got_status.cursor !== want_status.cursor) begin
                        $error("cursor_address: expected %0h actual %0h",
                               want_status.cursor, got_status.cursor);
                        err_count++;
                    end
                    if (got_status.origin !== want_status.origin) begin
                        $error("origin_address: expected %0h actual %0h",
                               want_status.origin, got_status.origin);
                        err_count++;
                    end
                    if (got_status.data !== want_status.data) begin
                        $error("read_data: expected %0h actual %0h",
                               want_status.data, got_status.data);
                        err_count++;
                    end
                end
            end
            res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_put(logic [CHAR_W-1:0] c);
        pend_q.push_back('{CMD_PUT, c, ADDR_W'($urandom_range(0, MEM_WORDS - 1))});
    endtask

    task automatic queue_read(logic [ADDR_W-1:0] a);
        pend_q.push_back('{CMD_READ, CHAR_W'($urandom_range(0, 255)), a});
    endtask

    function automatic logic [ADDR_W-1:0] pick_read_addr();
        int sel;
        sel = $urandom_range(2);
        if (sel == 0)
            return ADDR_W'($urandom_range(0, MEM_WORDS - 1));
        else if (sel == 1)
            return ADDR_W'(wrap_word(crs_word + MEM_WORDS - $urandom_range(0, 100)));
        return ADDR_W'(wrap_word(scr_origin + $urandom_range(0, ROWS * COLS - 1)));
    endfunction

    // one random step: a single item or a run of 60 to 100 characters, maybe with a newline
    task automatic queue_segment(output int n);
        int                r;
        int                len;
        logic [CHAR_W-1:0] c;
        r = $urandom_range(99);
        n = 1;
        if (r < 15) begin
            queue_read(pick_read_addr());
        end else if (r < 23) begin
            len = $urandom_range(60, 100);
            for (int k = 0; k < len; k++) begin
                c = CHAR_W'($urandom_range(0, 255));
                if (c == CODE_NEWLINE || c == CODE_RETURN || c == CODE_BACKSPACE)
                    c = 8'h2A;
                queue_put(c);
            end
            n = len;
            if ($urandom_range(1)) begin
                queue_put(CODE_NEWLINE);
                n++;
            end
        end else if (r < 50) begin
            queue_put(CODE_NEWLINE);
        end else if (r < 56) begin
            queue_put(CODE_RETURN);
        end else if (r < 66) begin
            queue_put(CODE_BACKSPACE);
        end else begin
            queue_put(CHAR_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(int total, int send_pct, int recv_pct);
        int done_n;
        int n;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        done_n = 0;
        while (done_n < total) begin
            @(negedge i_clk);
            if (pend_q.size() < 2) begin
                queue_segment(n);
                done_n += n;
            end
        end
    endtask

    task automatic wait_drained();
        while (pend_q.size() != 0 || in_valid || status_due_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_attr(logic [ATTR_W-1:0] v);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        txt_attr = v;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        for (int i = 0; i < MEM_WORDS; i++)
            vram[i] = BLANK_WORD;
        scr_origin = 0;
        crs_row    = 0;
        crs_col    = 0;
        crs_word   = 0;
        txt_attr   = ATTR_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: edges of the fields and each control code
        queue_read('0);
        queue_read('1);
        queue_put(CODE_BACKSPACE);
        queue_put(8'h41);
        queue_put(8'h00);
        queue_put(8'hFF);
        queue_put(CODE_BACKSPACE);
        queue_read(13'd1);
        queue_put(CODE_RETURN);
        queue_read(13'd0);
        queue_put(CODE_NEWLINE);
        queue_put(CODE_BACKSPACE);
        queue_read(13'd159);
        queue_put(CODE_NEWLINE);
        queue_put(CODE_NEWLINE);
        queue_put(8'h7F);
        queue_put(8'h80);
        queue_read(13'h1555);
        queue_read(13'h0AAA);
        queue_put(CODE_RETURN);
        queue_put(CODE_NEWLINE);
        queue_read(13'd240);

        run_random(220, 0, 0);
        wait_drained();
        write_attr(8'hFF);
        run_random(210, 75, 0);
        wait_drained();
        write_attr(8'h00);
        run_random(210, 0, 75);
        wait_drained();
        write_attr(ATTR_W'($urandom_range(1, 254)));
        run_random(210, 36, 36);
        wait_drained();
        write_attr(ATTR_W'($urandom_range(0, 255)));
        run_random(200, 0, 0);
        wait_drained();
        repeat (50) @(posedge i_clk);

        if (err_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

[sim.f]
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_datapath.sv
hdl/tcw_ctrl.sv
hdl/text_console_writer.sv
dv/tb.sv
